// ===== design/tmkss_pkg.sv =====
package tmkss_pkg;

    localparam int SLOT_W          = 5;
    localparam int CLASS_W         = 4;
    localparam int TIER_OUT_W      = 2;
    localparam int KEY_W           = 32;
    localparam int CEIL_W          = 31;
    localparam int SLOT_COUNT_DEF  = 32;
    localparam int CLASS_TIERS_DEF = 4;
    localparam logic [CEIL_W-1:0] CEILING_RESET = 31'h0100_0000;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                    cmd;
        logic [SLOT_W-1:0]       slot;
        logic [CLASS_W-1:0]      class_value;
        logic signed [KEY_W-1:0] key_value;
        logic [SLOT_W-1:0]       first_slot;
        logic [SLOT_W-1:0]       last_slot;
    } item_t;

    typedef struct packed {
        logic                  found;
        logic [SLOT_W-1:0]     chosen_slot;
        logic [TIER_OUT_W-1:0] chosen_class;
    } result_t;

    typedef struct packed {
        logic [CLASS_W-1:0]      class_value;
        logic signed [KEY_W-1:0] key_value;
    } slot_entry_t;

    // microcode
    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_ENTRY = 3'd1;
    localparam step_t STEP_TIER  = 3'd2;
    localparam step_t STEP_PRIME = 3'd3;
    localparam step_t STEP_SCAN  = 3'd4;
    localparam step_t STEP_EVAL  = 3'd5;
    localparam step_t STEP_EMIT  = 3'd6;

    typedef logic [2:0] cond_t;

    localparam cond_t COND_NONE  = 3'd0;
    localparam cond_t COND_QUERY = 3'd1;
    localparam cond_t COND_EMPTY = 3'd2;
    localparam cond_t COND_LAST  = 3'd3;
    localparam cond_t COND_DONE  = 3'd4;

    typedef struct packed {
        logic  op_load;
        logic  op_init;
        logic  op_advance;
        logic  op_compare;
        logic  op_next_tier;
        logic  op_emit;
        cond_t cond;
        step_t jump;
        step_t next;
    } ucode_t;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        w = '0;
        case (step)
            STEP_IDLE:
            begin
                w.cond = COND_QUERY;
                w.jump = STEP_ENTRY;
                w.next = STEP_IDLE;
            end
            STEP_ENTRY:
            begin
                w.op_load = 1'b1;
                w.cond    = COND_EMPTY;
                w.jump    = STEP_EMIT;
                w.next    = STEP_TIER;
            end
            STEP_TIER:
            begin
                w.op_init = 1'b1;
                w.next    = STEP_PRIME;
            end
            STEP_PRIME:
            begin
                w.op_advance = 1'b1;
                w.next       = STEP_SCAN;
            end
            STEP_SCAN:
            begin
                w.op_advance = 1'b1;
                w.op_compare = 1'b1;
                w.cond       = COND_LAST;
                w.jump       = STEP_EVAL;
                w.next       = STEP_SCAN;
            end
            STEP_EVAL:
            begin
                w.op_next_tier = 1'b1;
                w.cond         = COND_DONE;
                w.jump         = STEP_EMIT;
                w.next         = STEP_TIER;
            end
            STEP_EMIT:
            begin
                w.op_emit = 1'b1;
                w.next    = STEP_IDLE;
            end
            default:
            begin
                w.next = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== design/tiered_min_key_slot_select.sv =====
// Tiered minimum-key slot selector.
// Input word channel: item is taken at a rising edge with start high and busy low.
// A write word (cmd = write) stores class and key into one slot in that edge;
// busy stays low and no result follows, so writes can come every idle cycle.
// A query word (cmd = query) scans its inclusive slot range tier by tier,
// class 0 first, for the smallest key below key_ceiling (lowest slot on ties).
// Result channel: result is valid for exactly one cycle while done is high;
// the receiver cannot stall, so it must take the word in that cycle.
// A query over an empty range goes straight to the result without a scan;
// otherwise tiers are scanned in turn, at most CLASS_TIERS of them, stopping
// after the first tier that holds a hit. busy falls when done rises, so the
// next word is taken at the edge ending the done cycle; until then none is taken.
// The pace is set by the single slot memory read port: one slot compared per
// cycle, under a small microcoded sequencer.
// The user writes key_ceiling via cfg_we / cfg_wdata only while the block is idle;
// the block does not enforce this. Reset clears the sequencer and loads key_ceiling
// with 16777216; the slot table is not cleared and is meaningless until written.
module tiered_min_key_slot_select
    import tmkss_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int CLASS_TIERS = CLASS_TIERS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  item_t             item,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [CEIL_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(SLOT_COUNT);
    localparam int CMP_W  = (ADDR_W + 1 > SLOT_W) ? ADDR_W + 1 : SLOT_W;
    localparam int TIER_W = (CLASS_TIERS > 1) ? $clog2(CLASS_TIERS) : 1;

    slot_entry_t slot_mem [SLOT_COUNT];

    step_t                   step_reg, step_next;
    logic                    done_reg;
    result_t                 result_reg;
    logic [CEIL_W-1:0]       ceiling_reg;
    logic [ADDR_W-1:0]       first_reg, last_reg, idx_reg, cur_reg, pick_reg;
    logic                    empty_reg;
    logic [TIER_W-1:0]       tier_reg;
    logic signed [KEY_W-1:0] best_reg;
    logic                    hit_reg;
    slot_entry_t             rd_reg;

    ucode_t            cw;
    logic              cond_true;
    logic              accept;
    logic              wr_en;
    logic [ADDR_W-1:0] last_eff;
    logic              range_empty;
    logic              better;

    assign accept = start && !busy;
    assign wr_en  = accept && (item.cmd == CMD_WRITE)
                    && (CMP_W'(item.slot) < CMP_W'(SLOT_COUNT));

    assign last_eff = (CMP_W'(item.last_slot) >= CMP_W'(SLOT_COUNT))
                      ? ADDR_W'(SLOT_COUNT - 1) : ADDR_W'(item.last_slot);
    assign range_empty = CMP_W'(item.first_slot) > CMP_W'(last_eff);

    assign better = (rd_reg.class_value == CLASS_W'(tier_reg))
                    && (rd_reg.key_value < best_reg);

    assign cw = ucode_rom(step_reg);

    always_comb
    begin
        case (cw.cond)
            COND_NONE:  cond_true = 1'b0;
            COND_QUERY: cond_true = accept && (item.cmd == CMD_QUERY);
            COND_EMPTY: cond_true = empty_reg;
            COND_LAST:  cond_true = (cur_reg == last_reg);
            COND_DONE:  cond_true = hit_reg || (tier_reg == TIER_W'(CLASS_TIERS - 1));
            default:    cond_true = 1'b0;
        endcase
        step_next = cond_true ? cw.jump : cw.next;
    end

    // slot table
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[ADDR_W'(item.slot)] <= '{class_value: item.class_value,
                                             key_value:   item.key_value};
        end
        rd_reg <= slot_mem[idx_reg];
    end

    // sequencer and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= STEP_IDLE;
            done_reg    <= 1'b0;
            ceiling_reg <= CEILING_RESET;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= cw.op_emit;
            if (cfg_we)
            begin
                ceiling_reg <= cfg_wdata;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept && (item.cmd == CMD_QUERY))
        begin
            first_reg <= ADDR_W'(item.first_slot);
            last_reg  <= last_eff;
            empty_reg <= range_empty;
        end
        if (cw.op_load)
        begin
            tier_reg <= '0;
            hit_reg  <= 1'b0;
        end
        if (cw.op_init)
        begin
            idx_reg  <= first_reg;
            best_reg <= KEY_W'({1'b0, ceiling_reg});
            hit_reg  <= 1'b0;
        end
        if (cw.op_advance)
        begin
            cur_reg <= idx_reg;
            if (idx_reg != last_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
        if (cw.op_compare && better)
        begin
            best_reg <= rd_reg.key_value;
            pick_reg <= cur_reg;
            hit_reg  <= 1'b1;
        end
        if (cw.op_next_tier && !cond_true)
        begin
            tier_reg <= tier_reg + 1'b1;
        end
        if (cw.op_emit)
        begin
            result_reg.found        <= hit_reg;
            result_reg.chosen_slot  <= hit_reg ? SLOT_W'(pick_reg) : '0;
            result_reg.chosen_class <= hit_reg ? TIER_OUT_W'(tier_reg) : '0;
        end
    end

    assign busy   = (step_reg != STEP_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(step_reg == STEP_EMIT))
        else $error("result strobe without emit step");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_WRITE) |=> !busy && !done)
        else $error("write word started a query");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_SCAN) |-> (cur_reg >= first_reg && cur_reg <= last_reg))
        else $error("scan slot outside query range");

endmodule
